@@ hdl/lts_pkg.sv @@
// lts_pkg: shared widths, status codes and controller/datapath interface types
// for the lower triangular solver; no dependencies
package lts_pkg;

    localparam int COEF_W    = 32;
    localparam int ROW_W     = 10;
    localparam int STAT_W    = 2;
    localparam int SIZE_W    = 11;
    localparam int SUM_W     = 64;
    localparam int DIV_STEPS = 64;
    localparam int CNT_W     = 6;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_ZERO_DIAG = 2'd1;
    localparam logic [STAT_W-1:0] ST_SATURATED = 2'd2;

    typedef struct packed {
        logic capture;
        logic mac_mul;
        logic mac_acc;
        logic div_prep;
        logic div_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic off_diag;
        logic coef_zero;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

@@ hdl/lts_ctrl.sv @@
// lts_ctrl: sequencing state machine for the lower triangular solver
// depends on lts_pkg for the command and status types
module lts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  lts_pkg::t_sts i_sts,
    output logic          o_in_stall,
    output lts_pkg::t_cmd o_cmd
);
    import lts_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_PREP,
        S_DIV,
        S_DONE
    } t_state;

    t_state r_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        o_cmd          = '0;
        o_cmd.capture  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.mac_mul  = (r_state == S_MUL);
        o_cmd.mac_acc  = (r_state == S_ACC);
        o_cmd.div_prep = (r_state == S_PREP);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.finish   = (r_state == S_DONE) && i_sts.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= i_sts.off_diag ? S_MUL : S_PREP;
                    end
                end
                S_MUL: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_state <= S_IDLE;
                end
                S_PREP: begin
                    r_state <= i_sts.coef_zero ? S_DONE : S_DIV;
                end
                S_DIV: begin
                    if (i_sts.div_last) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hdl/lts_datapath.sv @@
// lts_datapath: solution store, multiply-accumulate, radix-2 divider and output register
// depends on lts_pkg; driven by lts_ctrl commands
module lts_datapath #(
    parameter int MAX_UNKNOWNS = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lts_pkg::t_cmd                        i_cmd,
    output lts_pkg::t_sts                        o_sts,
    input  logic                                 i_cfg_we,
    input  logic [lts_pkg::SIZE_W-1:0]           i_cfg_data,
    input  logic signed [lts_pkg::COEF_W-1:0]    i_coefficient,
    input  logic signed [lts_pkg::COEF_W-1:0]    i_right_side,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [lts_pkg::COEF_W-1:0]    o_solution,
    output logic [lts_pkg::ROW_W-1:0]            o_row_index,
    output logic                                 o_last_row,
    output logic [lts_pkg::STAT_W-1:0]           o_status
);
    import lts_pkg::*;

    localparam int RW = $clog2(MAX_UNKNOWNS);
    localparam int NW = $clog2(MAX_UNKNOWNS + 1);

    logic [COEF_W-1:0]        r_store [MAX_UNKNOWNS];
    logic [COEF_W-1:0]        r_x_rd;
    logic [COEF_W-1:0]        r_coef;
    logic [COEF_W-1:0]        r_rhs;
    logic signed [SUM_W-1:0]  r_prod;
    logic [SUM_W-1:0]         r_sum;
    logic [RW-1:0]            r_row;
    logic [RW-1:0]            r_col;
    logic [NW-1:0]            r_n;
    logic [SUM_W-1:0]         r_quo;
    logic [COEF_W-1:0]        r_rem;
    logic [COEF_W-1:0]        r_dmag;
    logic                     r_neg;
    logic [CNT_W-1:0]         r_cnt;

    logic [31:0]              eff32;
    logic [SUM_W-1:0]         a64;
    logic                     neg_num;
    logic [SUM_W-1:0]         mag;
    logic [COEF_W:0]          rem_sh;
    logic [COEF_W+1:0]        trial;
    logic                     ge;
    logic [COEF_W-1:0]        q;
    logic [STAT_W-1:0]        q_st;
    logic                     last;
    logic [RW-1:0]            n_row;

    // effective system size
    always_comb begin
        if (i_cfg_data == '0) begin
            eff32 = 32'd1;
        end else if (32'(i_cfg_data) > 32'(MAX_UNKNOWNS)) begin
            eff32 = 32'(MAX_UNKNOWNS);
        end else begin
            eff32 = 32'(i_cfg_data);
        end
    end

    // numerator magnitude and sign
    always_comb begin
        a64     = {{16{r_rhs[COEF_W-1]}}, r_rhs, 16'h0000};
        neg_num = $signed(a64) < $signed(r_sum);
        mag     = neg_num ? (r_sum - a64) : (a64 - r_sum);
    end

    // one restoring divide step
    always_comb begin
        rem_sh = {r_rem, r_quo[SUM_W-1]};
        trial  = {1'b0, rem_sh} - {2'b00, r_dmag};
        ge     = !trial[COEF_W+1];
    end

    // quotient sign, saturation and status
    always_comb begin
        q    = '0;
        q_st = ST_OK;
        if (r_coef == '0) begin
            q_st = ST_ZERO_DIAG;
        end else if (r_neg) begin
            if (r_quo > 64'h0000_0000_8000_0000) begin
                q    = 32'h8000_0000;
                q_st = ST_SATURATED;
            end else begin
                q = 32'd0 - r_quo[COEF_W-1:0];
            end
        end else begin
            if (r_quo > 64'h0000_0000_7FFF_FFFF) begin
                q    = 32'h7FFF_FFFF;
                q_st = ST_SATURATED;
            end else begin
                q = r_quo[COEF_W-1:0];
            end
        end
    end

    assign last  = (NW'(r_row) + NW'(1)) == r_n;
    assign n_row = last ? '0 : r_row + RW'(1);

    always_comb begin
        o_sts.off_diag  = r_col < r_row;
        o_sts.coef_zero = (r_coef == '0);
        o_sts.div_last  = (r_cnt == CNT_W'(DIV_STEPS - 1));
        o_sts.out_free  = !o_out_valid || !i_out_stall;
    end

    // solution store
    always_ff @(posedge i_clk) begin
        r_x_rd <= r_store[r_col];
        if (i_cmd.finish) begin
            r_store[r_row] <= q;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_coef <= i_coefficient;
            r_rhs  <= i_right_side;
        end
        if (i_cmd.mac_mul) begin
            r_prod <= $signed(r_x_rd) * $signed(r_coef);
        end
        if (i_cmd.div_prep) begin
            r_quo  <= mag;
            r_rem  <= '0;
            r_dmag <= r_coef[COEF_W-1] ? (32'd0 - r_coef) : r_coef;
            r_neg  <= neg_num ^ r_coef[COEF_W-1];
            r_cnt  <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[SUM_W-2:0], ge};
            r_rem <= ge ? trial[COEF_W-1:0] : rem_sh[COEF_W-1:0];
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.finish) begin
            o_solution  <= q;
            o_row_index <= ROW_W'(r_row);
            o_last_row  <= last;
            o_status    <= q_st;
        end
    end

    // row, column, sum and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n         <= NW'(1);
            r_row       <= '0;
            r_col       <= '0;
            r_sum       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_n   <= eff32[NW-1:0];
                r_row <= '0;
                r_col <= '0;
                r_sum <= '0;
            end else if (i_cmd.finish) begin
                r_row <= n_row;
                r_col <= '0;
                r_sum <= '0;
            end else if (i_cmd.mac_acc) begin
                r_col <= r_col + RW'(1);
                r_sum <= r_sum + r_prod;
            end
            if (i_cmd.finish) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

endmodule

@@ hdl/lower_triangular_solver_core.sv @@
// lower_triangular_solver_core: forward substitution, Q16.16, one coefficient per item
// off-diagonal item: store read, multiply, accumulate, then next item taken
// diagonal item: prep, 64-step divider, then finish into the output register, then next item taken
// zero diagonal skips the divider: prep, then finish; a full, stalled output register holds finish
// synchronous active-low reset: size 1, row/column/sum zero, output empty; store not cleared
// depends on lts_pkg, lts_ctrl, lts_datapath
module lower_triangular_solver_core #(
    parameter int MAX_UNKNOWNS = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [lts_pkg::SIZE_W-1:0]           i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [lts_pkg::COEF_W-1:0]    i_coefficient,
    input  logic signed [lts_pkg::COEF_W-1:0]    i_right_side,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [lts_pkg::COEF_W-1:0]    o_solution,
    output logic [lts_pkg::ROW_W-1:0]            o_row_index,
    output logic                                 o_last_row,
    output logic [lts_pkg::STAT_W-1:0]           o_status
);
    import lts_pkg::*;

    t_cmd cmd;
    t_sts sts;

    lts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    lts_datapath #(
        .MAX_UNKNOWNS (MAX_UNKNOWNS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_coefficient (i_coefficient),
        .i_right_side  (i_right_side),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_solution    (o_solution),
        .o_row_index   (o_row_index),
        .o_last_row    (o_last_row),
        .o_status      (o_status)
    );

endmodule

@@ tb/sv/tb_lower_triangular_solver_core.sv @@
// tb_lower_triangular_solver_core: self-checking testbench for the forward substitution core,
// predicts every solution item in Q16.16 and checks it under random input gaps and output stalls
// depends on lts_pkg and lower_triangular_solver_core
module tb_lower_triangular_solver_core;
    timeunit 1ns;
    timeprecision 1ps;

    import lts_pkg::*;

    localparam int          HALF_PERIOD  = 6;
    localparam int          MAX_UNK      = 1024;
    localparam int          RANDOM_ITEMS = 1250;
    localparam int          HOLD_CYCLES  = 500;
    localparam int          SETTLE       = 80;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;

    typedef struct packed {
        logic signed [COEF_W-1:0] solution;
        logic [ROW_W-1:0]         row_index;
        logic                     last_row;
        logic [STAT_W-1:0]        status;
    } t_solution;

    typedef enum {VAL_SCALED, VAL_RAW} t_value_mode;
    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [SIZE_W-1:0]        i_cfg_data;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic signed [COEF_W-1:0] i_coefficient;
    logic signed [COEF_W-1:0] i_right_side;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic signed [COEF_W-1:0] o_solution;
    logic [ROW_W-1:0]         o_row_index;
    logic                     o_last_row;
    logic [STAT_W-1:0]        o_status;

    // solver state as seen by the predictor
    logic [SIZE_W-1:0]        size_now;
    longint                   acc_sum;
    int unsigned              row_now;
    int unsigned              col_now;
    logic signed [COEF_W-1:0] solved [MAX_UNK];

    t_solution   pending_solutions[$];
    int          error_count = 0;
    int          items_sent = 0;
    int          burst_left = 0;
    bit          steady_send = 1'b0;
    bit          hold_pending = 1'b0;
    int unsigned cycle_count = 0;

    lower_triangular_solver_core #(
        .MAX_UNKNOWNS(MAX_UNK)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_coefficient(i_coefficient),
        .i_right_side (i_right_side),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_solution   (o_solution),
        .o_row_index  (o_row_index),
        .o_last_row   (o_last_row),
        .o_status     (o_status)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int unsigned effective_size(input logic [SIZE_W-1:0] size);
        if (size == 0) return 1;
        if (size > MAX_UNK) return MAX_UNK;
        return size;
    endfunction

    function automatic void restart_system(input logic [SIZE_W-1:0] size);
        size_now = size;
        acc_sum  = 0;
        row_now  = 0;
        col_now  = 0;
    endfunction

    function automatic bit forward_substitute(input logic signed [COEF_W-1:0] coef,
                                              input logic signed [COEF_W-1:0] rhs,
                                              output t_solution sol);
        int unsigned       n;
        longint            num;
        longint            q;
        longint unsigned   mag;
        longint unsigned   dmag;
        longint unsigned   qm;
        bit                neg_num;
        bit                neg_den;
        logic [STAT_W-1:0] st;
        n = effective_size(size_now);
        sol = '0;
        if (row_now >= n) begin
            acc_sum = 0;
            row_now = 0;
            col_now = 0;
        end
        if (col_now < row_now) begin
            acc_sum = acc_sum + longint'(solved[col_now]) * longint'(coef);
            col_now++;
            return 1'b0;
        end
        st = ST_OK;
        q  = 0;
        if (coef == 0) begin
            st = ST_ZERO_DIAG;
        end else begin
            num     = longint'(rhs) * 65536;
            neg_num = num < acc_sum;
            mag     = neg_num ? acc_sum - num : num - acc_sum;
            neg_den = coef < 0;
            dmag    = neg_den ? -longint'(coef) : longint'(coef);
            qm      = mag / dmag;
            if (neg_num != neg_den) begin
                if (qm > 64'h8000_0000) begin
                    qm = 64'h8000_0000;
                    st = ST_SATURATED;
                end
                q = -longint'(qm);
            end else begin
                if (qm > 64'h7FFF_FFFF) begin
                    qm = 64'h7FFF_FFFF;
                    st = ST_SATURATED;
                end
                q = longint'(qm);
            end
        end
        solved[row_now]  = q[COEF_W-1:0];
        sol.solution     = q[COEF_W-1:0];
        sol.row_index    = row_now[ROW_W-1:0];
        sol.last_row     = (row_now + 1 == n);
        sol.status       = st;
        acc_sum = 0;
        col_now = 0;
        row_now = (row_now + 1 >= n) ? 0 : row_now + 1;
        return 1'b1;
    endfunction

    task automatic report_error(input string what, input longint got, input longint want);
        $display("ERROR cycle %0d: %s: got %0d, expected %0d", cycle_count, what, got, want);
        error_count++;
    endtask

    // result checker
    always @(posedge i_clk) begin : check_results
        t_solution want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_solutions.size() == 0) begin
                report_error("unexpected item, solution", o_solution, 0);
            end else begin
                want = pending_solutions.pop_front();
                if (o_solution !== want.solution)
                    report_error("solution", o_solution, want.solution);
                if (o_row_index !== want.row_index)
                    report_error("row_index", o_row_index, want.row_index);
                if (o_last_row !== want.last_row)
                    report_error("last_row", o_last_row, want.last_row);
                if (o_status !== want.status)
                    report_error("status", o_status, want.status);
            end
        end
    end

    // output stall pattern, with a long hold-off on request
    initial begin : out_stall_gen
        t_stall_mode mode;
        int          mode_left;
        int          hold_left;
        int          phase;
        mode        = STALL_NONE;
        mode_left   = 0;
        hold_left   = 0;
        phase       = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_pending) begin
                hold_left    = HOLD_CYCLES;
                hold_pending = 1'b0;
            end
            if (mode_left == 0) begin
                mode      = t_stall_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            phase++;
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall = 1'b1;
            end else begin
                case (mode)
                    STALL_NONE:     i_out_stall = 1'b0;
                    STALL_LIGHT:    i_out_stall = ($urandom_range(0, 2) == 0);
                    STALL_HEAVY:    i_out_stall = ($urandom_range(0, 3) != 0);
                    default:        i_out_stall = (phase % 7 < 3);
                endcase
            end
        end
    end

    task automatic idle_input(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_in_valid    = 1'b0;
            i_coefficient = $urandom;
            i_right_side  = $urandom;
        end
    endtask

    task automatic send_item(input logic signed [COEF_W-1:0] coef,
                             input logic signed [COEF_W-1:0] rhs);
        t_solution sol;
        int        pick;
        if (burst_left == 0 && !steady_send) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)      idle_input($urandom_range(0, 3));
            else if (pick < 95) idle_input($urandom_range(4, 20));
            else                idle_input($urandom_range(21, 80));
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end
        @(negedge i_clk);
        i_in_valid    = 1'b1;
        i_coefficient = coef;
        i_right_side  = rhs;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (forward_substitute(coef, rhs, sol))
            pending_solutions.push_back(sol);
        if (burst_left > 0) burst_left--;
        items_sent++;
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] size);
        idle_input(1);
        while (pending_solutions.size() != 0) @(posedge i_clk);
        // an off-diagonal item may still be in the datapath
        idle_input(SETTLE);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = size;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        i_cfg_data = $urandom;
        restart_system(size);
    endtask

    function automatic logic signed [COEF_W-1:0] pick_coef(input t_value_mode mode,
                                                           input bit diag);
        int mag;
        if (diag && $urandom_range(0, 24) == 0) return '0;
        if (mode == VAL_RAW) return $urandom;
        if (diag) begin
            mag = $urandom_range(32'h8000, 32'h40000);
            return $urandom_range(0, 1) ? -mag : mag;
        end
        return int'($urandom_range(0, 32'h10000)) - 32'sh8000;
    endfunction

    function automatic logic signed [COEF_W-1:0] pick_rhs(input t_value_mode mode);
        if (mode == VAL_RAW) return $urandom;
        return int'($urandom_range(0, 32'h200000)) - 32'sh100000;
    endfunction

    // full rows starting at row 0, wrapping into new systems
    task automatic send_rows(input int unsigned n, input int rows, input t_value_mode mode);
        int unsigned r;
        for (int k = 0; k < rows; k++) begin
            r = k % n;
            for (int unsigned c = 0; c < r; c++)
                send_item(pick_coef(mode, 1'b0), $urandom);
            send_item(pick_coef(mode, 1'b1), pick_rhs(mode));
        end
    endtask

    task automatic test_single_unknown();
        send_item(32'sh0001_0000, 32'sh7FFF_FFFF);
        send_item(32'sh0000_0001, 32'sh0000_0001);
        send_item(32'sh0000_0000, 32'sh1234_5678);
        send_item(32'sh8000_0000, 32'sh8000_0000);
        send_item(32'shFFFF_FFFF, 32'sh7FFF_FFFF);
        send_item(32'sh0001_0000, 32'sh8000_0000);
    endtask

    task automatic test_size_extremes();
        write_size(11'd0);
        send_item(32'sh0002_0000, 32'sh0003_0000);
        send_item(32'shFFFF_0000, 32'sh0001_8000);
        write_size(11'd2);
        send_item(32'sh0001_0000, 32'sh0005_0000);
        send_item(32'sh7FFF_FFFF, 32'sh0000_0000);
        send_item(32'sh0001_0000, 32'sh0000_0000);
        write_size(11'd3);
        send_item(32'sh0000_8000, 32'sh7FFF_FFFF);
        send_item(32'sh8000_0000, 32'sh5555_5555);
        send_item(32'sh7FFF_FFFF, 32'shAAAA_AAAA);
        send_item(32'sh7FFF_FFFF, 32'sh0000_0000);
        send_item(32'sh8000_0000, 32'sh0000_0000);
        send_item(32'shFFFF_FFFF, 32'sh8000_0000);
        write_size(11'd2047);
        send_item(32'sh0001_0000, 32'sh0001_0000);
        send_item(32'sh0000_4000, 32'sh0000_0000);
        send_item(32'sh0004_0000, 32'sh0008_0000);
        write_size(11'd1024);
        send_item(32'shFFFE_0000, 32'sh0010_0000);
    endtask

    task automatic test_output_backpressure();
        write_size(11'd4);
        steady_send  = 1'b1;
        hold_pending = 1'b1;
        send_rows(4, 8, VAL_SCALED);
        steady_send  = 1'b0;
    endtask

    task automatic test_random_systems();
        int              start;
        int              pick;
        int unsigned     n;
        int              rows;
        logic [SIZE_W-1:0] size;
        t_value_mode     mode;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)      size = $urandom_range(2, 6);
            else if (pick < 85) size = $urandom_range(7, 16);
            else if (pick < 95) size = $urandom_range(0, 1);
            else                size = $urandom_range(1024, 2047);
            write_size(size);
            n    = effective_size(size);
            rows = (n == MAX_UNK) ? $urandom_range(1, 6) : n * $urandom_range(1, 3);
            mode = ($urandom_range(0, 4) == 0) ? VAL_RAW : VAL_SCALED;
            send_rows(n, rows, mode);
            // stop partway into a row, the next size write restarts the system
            if (rows % n != 0 && $urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, rows % n))
                    send_item(pick_coef(mode, 1'b0), $urandom);
        end
    endtask

    initial begin
        int wait_cycles;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_coefficient = '0;
        i_right_side  = '0;
        foreach (solved[k]) solved[k] = '0;
        restart_system(11'd1);
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_single_unknown();
        test_size_extremes();
        test_output_backpressure();
        test_random_systems();

        idle_input(1);
        wait_cycles = 0;
        while (pending_solutions.size() != 0 && wait_cycles < 5000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (SETTLE) @(posedge i_clk);
        if (pending_solutions.size() != 0)
            report_error("items never delivered", pending_solutions.size(), 0);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
